>>> rtl/item_table_sort_search_assert.svh
// assertion macros for the item table checker
`ifndef ITEM_TABLE_SORT_SEARCH_ASSERT_SVH
`define ITEM_TABLE_SORT_SEARCH_ASSERT_SVH

`define ITS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ITS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/its_pkg.sv
// shared types and constants for the item table
`default_nettype none
package its_pkg;
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LIST   = 3'd2;
    localparam logic [2:0] OP_SEQ    = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;
    localparam logic [2:0] OP_BIN    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam int REC_W = 64 * 3 + 48 + 64 * 2 + 32 + 32;
    localparam int KEY_W = 240;

    // ram write data select
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_HOLD_A,
        SRC_HOLD_B,
        SRC_RDATA
    } src_sel_t;

    // datapath commands from the controller
    typedef struct packed {
        logic       load_in;
        logic       rd_en;
        logic       wr_en;
        src_sel_t   wr_src;
        logic       hold_a;
        logic       hold_b;
        logic       emit;
        logic       emit_rec;
        logic       emit_last;
        logic [1:0] emit_status;
    } dp_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic eq;
        logic lt;
        logic gt_ab;
    } dp_stat_t;
endpackage
`default_nettype wire

>>> rtl/its_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module its_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/its_datapath.sv
// record store, compare unit and result registers
`default_nettype none
module its_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  its_pkg::dp_cmd_t                 cmd,
    input  wire logic [$clog2(CAPACITY)-1:0] raddr,
    input  wire logic [$clog2(CAPACITY)-1:0] waddr,
    input  wire logic [4:0]                  emit_cmps,
    input  wire logic [$clog2(CAPACITY)-1:0] emit_pos,
    input  wire logic [its_pkg::REC_W-1:0]   in_rec,
    output its_pkg::dp_stat_t                stat,
    output logic                             strobe,
    output logic [1:0]                       status,
    output logic [3:0]                       position,
    output logic [4:0]                       compare_count,
    output logic [its_pkg::REC_W-1:0]        out_rec,
    output logic                             last
);
    import its_pkg::*;

    logic [REC_W-1:0] key_reg;
    logic [REC_W-1:0] a_reg;
    logic [REC_W-1:0] b_reg;
    logic [REC_W-1:0] rdata;
    logic [REC_W-1:0] wdata;
    logic [KEY_W-1:0] rkey;

    // one ram holding the whole record
    its_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        unique case (cmd.wr_src)
            SRC_INPUT:  wdata = key_reg;
            SRC_HOLD_A: wdata = a_reg;
            SRC_HOLD_B: wdata = b_reg;
            default:    wdata = rdata;
        endcase
    end

    assign rkey     = rdata[REC_W-1 -: KEY_W];
    assign stat.eq  = rkey == key_reg[REC_W-1 -: KEY_W];
    assign stat.lt  = rkey < key_reg[REC_W-1 -: KEY_W];
    assign stat.gt_ab = a_reg[REC_W-1 -: KEY_W] > rkey;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            key_reg <= in_rec;
        end
        if (cmd.hold_a)
        begin
            a_reg <= rdata;
        end
        if (cmd.hold_b)
        begin
            b_reg <= rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe <= 1'b0;
        end
        else
        begin
            strobe <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status        <= cmd.emit_status;
            compare_count <= emit_cmps;
            last          <= cmd.emit_last;
            position      <= cmd.emit_rec ? 4'(emit_pos) : 4'd0;
            out_rec       <= cmd.emit_rec ? (cmd.wr_en ? key_reg : rdata) : '0;
        end
    end
endmodule
`default_nettype wire

>>> rtl/its_ctrl.sv
// operation sequencer for the item table
`default_nettype none
module its_ctrl #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [2:0]                  op,
    input  its_pkg::dp_stat_t                stat,
    output logic                             busy,
    output its_pkg::dp_cmd_t                 cmd,
    output logic [$clog2(CAPACITY)-1:0]      raddr,
    output logic [$clog2(CAPACITY)-1:0]      waddr,
    output logic [4:0]                       emit_cmps,
    output logic [$clog2(CAPACITY)-1:0]      emit_pos
);
    import its_pkg::*;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_RD, S_SEQ, S_REM_RD, S_REM_MV,
        S_LIST, S_BIN, S_SORT_A, S_SORT_B, S_SORT_C, S_SORT_W
    } state_t;

    state_t         state_reg, state_next;
    logic [2:0]     op_reg, op_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  lim_reg, lim_next;
    logic [CW:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]  mid_reg, mid_next;
    logic [4:0]     cmps_reg, cmps_next;
    logic           swp_reg, swp_next;

    always_comb
    begin
        logic [CW:0] m;
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        lim_next   = lim_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        cmps_next  = cmps_reg;
        swp_next   = swp_reg;
        cmd        = '0;
        raddr      = i_reg[AW-1:0];
        waddr      = i_reg[AW-1:0];
        emit_cmps  = 5'd0;
        emit_pos   = i_reg[AW-1:0];
        m          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = op;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                i_next = '0;
                cmps_next = '0;
                if (op_reg == OP_INSERT)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (cnt_reg >= CW'(CAPACITY))
                    begin
                        cmd.emit_status = ST_FULL;
                    end
                    else
                    begin
                        waddr = cnt_reg[AW-1:0];
                        emit_pos = cnt_reg[AW-1:0];
                        cmd.wr_en = 1'b1;
                        cmd.wr_src = SRC_INPUT;
                        cmd.emit_rec = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (op_reg > OP_BIN)
                begin
                    state_next = S_IDLE;
                end
                else if (op_reg == OP_SORT)
                begin
                    if (cnt_reg < CW'(2))
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_last = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lim_next = cnt_reg - 1'b1;
                        raddr = '0;
                        state_next = S_SORT_A;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                    state_next = S_IDLE;
                end
                else if (op_reg == OP_BIN)
                begin
                    lo_next = '0;
                    hi_next = (CW+1)'(cnt_reg) - 1'b1;
                    m = ((CW+1)'(cnt_reg) - 1'b1) >> 1;
                    mid_next = m[CW-1:0];
                    raddr = m[AW-1:0];
                    state_next = S_BIN;
                end
                else
                begin
                    raddr = '0;
                    state_next = op_reg == OP_LIST ? S_LIST
                               : op_reg == OP_SEQ ? S_SEQ : S_REM_RD;
                end
            end
            S_SEQ, S_REM_RD:
            begin
                emit_cmps = 5'(i_reg + 1'b1);
                if (stat.eq)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_rec = 1'b1;
                    if (state_reg == S_SEQ)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_cmps = '0;
                        raddr = AW'(i_reg + 1'b1);
                        state_next = S_REM_MV;
                    end
                end
                else if (i_reg + 1'b1 == cnt_reg)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_status = ST_NOTFOUND;
                    if (state_reg == S_REM_RD)
                    begin
                        emit_cmps = '0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    raddr = AW'(i_reg + 1'b1);
                end
            end
            S_REM_MV:
            begin
                if (i_reg + 1'b1 >= cnt_reg)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_src = SRC_RDATA;
                    i_next = i_reg + 1'b1;
                    raddr = AW'(i_reg + 2'd2);
                end
            end
            S_LIST:
            begin
                cmd.emit = 1'b1;
                cmd.emit_rec = 1'b1;
                if (i_reg + 1'b1 == cnt_reg)
                begin
                    cmd.emit_last = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    raddr = AW'(i_reg + 1'b1);
                end
            end
            S_BIN:
            begin
                emit_cmps = cmps_reg + 1'b1;
                emit_pos = mid_reg[AW-1:0];
                cmps_next = cmps_reg + 1'b1;
                if (stat.eq)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_rec = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (stat.lt)
                    begin
                        lo_next = (CW+1)'(mid_reg) + 1'b1;
                    end
                    else
                    begin
                        hi_next = (CW+1)'(mid_reg) - 1'b1;
                    end
                    if ($signed(lo_next) > $signed(hi_next))
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.emit_status = ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        m = (lo_next + hi_next) >> 1;
                        mid_next = m[CW-1:0];
                        raddr = m[AW-1:0];
                    end
                end
            end
            // i_reg = j, lim_reg = inner limit
            S_SORT_A:
            begin
                cmd.hold_a = 1'b1;
                raddr = AW'(i_reg + 1'b1);
                state_next = S_SORT_B;
            end
            S_SORT_B:
            begin
                cmd.hold_b = 1'b1;
                swp_next = stat.gt_ab;
                state_next = S_SORT_C;
            end
            S_SORT_C:
            begin
                if (swp_reg)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_src = SRC_HOLD_B;
                    state_next = S_SORT_W;
                end
                else
                begin
                    state_next = S_SORT_W;
                end
            end
            S_SORT_W:
            begin
                if (swp_reg)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_src = SRC_HOLD_A;
                    waddr = AW'(i_reg + 1'b1);
                end
                if (i_reg + 1'b1 >= lim_reg)
                begin
                    if (lim_reg <= CW'(1))
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_last = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lim_next = lim_reg - 1'b1;
                        i_next = '0;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                raddr = i_reg[AW-1:0];
                state_next = S_SORT_A;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            cnt_reg   <= '0;
            i_reg     <= '0;
            lim_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
            cmps_reg  <= '0;
            swp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            lim_reg   <= lim_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            cmps_reg  <= cmps_next;
            swp_reg   <= swp_next;
        end
    end

    assign busy = state_reg != S_IDLE;
endmodule
`default_nettype wire

>>> rtl/item_table_sort_search.sv
// item table: insert, remove, list, search and sort of named records
// result beats come one per cycle
// sort is a bubble sort that moves entries through the single ram write port
// one operation at a time; busy drops with the last beat, except remove,
// which stays busy while shifting later entries down
// reset clears the entry count and control; record storage is not cleared
`default_nettype none
module item_table_sort_search #(
    parameter int CAPACITY = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [2:0]   op,
    input  wire logic [63:0]  key_w0,
    input  wire logic [63:0]  key_w1,
    input  wire logic [63:0]  key_w2,
    input  wire logic [47:0]  key_w3,
    input  wire logic [63:0]  kind_w0,
    input  wire logic [63:0]  kind_w1,
    input  wire logic [31:0]  kind_w2,
    input  wire logic signed [31:0] amount,
    output logic              strobe,
    output logic [1:0]        status,
    output logic [3:0]        position,
    output logic [4:0]        compare_count,
    output logic [63:0]       out_key_w0,
    output logic [63:0]       out_key_w1,
    output logic [63:0]       out_key_w2,
    output logic [47:0]       out_key_w3,
    output logic [63:0]       out_kind_w0,
    output logic [63:0]       out_kind_w1,
    output logic [31:0]       out_kind_w2,
    output logic signed [31:0] out_amount,
    output logic              last
);
    import its_pkg::*;
    localparam int AW = $clog2(CAPACITY);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [AW-1:0]    raddr, waddr, emit_pos;
    logic [4:0]       emit_cmps;
    logic [REC_W-1:0] out_rec;

    its_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (op),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd),
        .raddr    (raddr),
        .waddr    (waddr),
        .emit_cmps(emit_cmps),
        .emit_pos (emit_pos)
    );

    its_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .raddr        (raddr),
        .waddr        (waddr),
        .emit_cmps    (emit_cmps),
        .emit_pos     (emit_pos),
        .in_rec       ({key_w0, key_w1, key_w2, key_w3, kind_w0, kind_w1, kind_w2, amount}),
        .stat         (stat),
        .strobe       (strobe),
        .status       (status),
        .position     (position),
        .compare_count(compare_count),
        .out_rec      (out_rec),
        .last         (last)
    );

    assign {out_key_w0, out_key_w1, out_key_w2, out_key_w3,
            out_kind_w0, out_kind_w1, out_kind_w2, out_amount} = out_rec;
endmodule
`default_nettype wire

>>> rtl/its_checker.sv
// port-level checks for the item table, bound to the top level
`default_nettype none
`include "item_table_sort_search_assert.svh"
module its_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       strobe,
    input wire logic       last,
    input wire logic [1:0] status,
    input wire logic [4:0] compare_count
);
    import its_pkg::*;

    `ITS_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ITS_ASSERT_IMPL(a_err_last, clk, rst_n, strobe && status != ST_OK, last)
    `ITS_ASSERT_IMPL(a_more_busy, clk, rst_n, strobe && !last, busy)
    `ITS_ASSERT_IMPL(a_full_nocmp, clk, rst_n, strobe && status == ST_FULL, compare_count == 5'd0)
endmodule

bind item_table_sort_search its_checker u_its_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .strobe       (strobe),
    .last         (last),
    .status       (status),
    .compare_count(compare_count)
);
`default_nettype wire

>>> tb/item_table_checker.sv
// checker for the item table: predicts result beats and compares them with the block
`timescale 1ns / 100ps
module item_table_checker
    import its_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire logic [2:0]   op,
    input  wire logic [63:0]  key_w0,
    input  wire logic [63:0]  key_w1,
    input  wire logic [63:0]  key_w2,
    input  wire logic [47:0]  key_w3,
    input  wire logic [63:0]  kind_w0,
    input  wire logic [63:0]  kind_w1,
    input  wire logic [31:0]  kind_w2,
    input  wire logic [31:0]  amount,
    input  wire logic         strobe,
    input  wire logic [1:0]   status,
    input  wire logic [3:0]   position,
    input  wire logic [4:0]   compare_count,
    input  wire logic [63:0]  out_key_w0,
    input  wire logic [63:0]  out_key_w1,
    input  wire logic [63:0]  out_key_w2,
    input  wire logic [47:0]  out_key_w3,
    input  wire logic [63:0]  out_kind_w0,
    input  wire logic [63:0]  out_kind_w1,
    input  wire logic [31:0]  out_kind_w2,
    input  wire logic [31:0]  out_amount,
    input  wire logic         last,
    output int                fail_count,
    output int                pending,
    output int                beat_count
);
    typedef struct {
        logic [1:0]   status;
        logic [3:0]   position;
        logic [4:0]   cmps;
        logic [239:0] name;
        logic [159:0] kind;
        logic [31:0]  amt;
        logic         last;
    } table_beat_t;

    table_beat_t  expected_beats[$];
    logic [239:0] names[CAPACITY];
    logic [159:0] kinds[CAPACITY];
    logic [31:0]  amts[CAPACITY];
    int           entries = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        beat_count = 0;
    end

    function automatic void push_beat(logic [1:0] st, int pos, int cmps, int idx, bit fin);
        table_beat_t b;
        b.status   = st;
        b.position = (idx >= 0) ? pos[3:0] : 4'd0;
        b.cmps     = cmps[4:0];
        b.name     = (idx >= 0) ? names[idx] : '0;
        b.kind     = (idx >= 0) ? kinds[idx] : '0;
        b.amt      = (idx >= 0) ? amts[idx] : '0;
        b.last     = fin;
        expected_beats.push_back(b);
    endfunction

    task automatic predict_table_op(logic [2:0] code, logic [239:0] name,
                                    logic [159:0] kind, logic [31:0] amt);
        int           lo;
        int           hi;
        int           mid;
        int           cmps;
        bit           hit;
        logic [239:0] tn;
        logic [159:0] tk;
        logic [31:0]  ta;
        hit = 0;
        if (code == OP_INSERT)
        begin
            if (entries >= CAPACITY)
                push_beat(ST_FULL, 0, 0, -1, 1);
            else
            begin
                names[entries] = name;
                kinds[entries] = kind;
                amts[entries]  = amt;
                push_beat(ST_OK, entries, 0, entries, 1);
                entries++;
            end
        end
        else if (code > OP_BIN)
        begin
        end
        else if (code != OP_SORT && entries == 0)
            push_beat(ST_EMPTY, 0, 0, -1, 1);
        else if (code == OP_REMOVE)
        begin
            for (int i = 0; i < entries && !hit; i++)
                if (names[i] == name)
                begin
                    hit = 1;
                    push_beat(ST_OK, i, 0, i, 1);
                    for (int j = i; j + 1 < entries; j++)
                    begin
                        names[j] = names[j + 1];
                        kinds[j] = kinds[j + 1];
                        amts[j]  = amts[j + 1];
                    end
                    entries--;
                end
            if (!hit)
                push_beat(ST_NOTFOUND, 0, 0, -1, 1);
        end
        else if (code == OP_LIST)
        begin
            for (int i = 0; i < entries; i++)
                push_beat(ST_OK, i, 0, i, i + 1 == entries);
        end
        else if (code == OP_SEQ)
        begin
            for (int i = 0; i < entries && !hit; i++)
                if (names[i] == name)
                begin
                    hit = 1;
                    push_beat(ST_OK, i, i + 1, i, 1);
                end
            if (!hit)
                push_beat(ST_NOTFOUND, 0, entries, -1, 1);
        end
        else if (code == OP_SORT)
        begin
            for (int i = 0; i + 1 < entries; i++)
                for (int j = 0; j + 1 < entries - i; j++)
                    if (names[j] > names[j + 1])
                    begin
                        tn = names[j]; names[j] = names[j + 1]; names[j + 1] = tn;
                        tk = kinds[j]; kinds[j] = kinds[j + 1]; kinds[j + 1] = tk;
                        ta = amts[j];  amts[j]  = amts[j + 1];  amts[j + 1]  = ta;
                    end
            push_beat(ST_OK, 0, 0, -1, 1);
        end
        else
        begin
            lo   = 0;
            hi   = entries - 1;
            cmps = 0;
            while (lo <= hi && !hit)
            begin
                mid = (lo + hi) / 2;
                cmps++;
                if (names[mid] == name)
                begin
                    hit = 1;
                    push_beat(ST_OK, mid, cmps, mid, 1);
                end
                else if (names[mid] < name)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            if (!hit)
                push_beat(ST_NOTFOUND, 0, cmps, -1, 1);
        end
    endtask

    function automatic void check_field(string field, logic [63:0] exp, logic [63:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %h, got %h", field, exp, act);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        table_beat_t b;
        if (rst_n)
        begin
            if (strobe)
            begin
                beat_count++;
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    b = expected_beats.pop_front();
                    check_field("status", b.status, status);
                    check_field("position", b.position, position);
                    check_field("compare_count", b.cmps, compare_count);
                    check_field("out_key_w0", b.name[239:176], out_key_w0);
                    check_field("out_key_w1", b.name[175:112], out_key_w1);
                    check_field("out_key_w2", b.name[111:48], out_key_w2);
                    check_field("out_key_w3", b.name[47:0], out_key_w3);
                    check_field("out_kind_w0", b.kind[159:96], out_kind_w0);
                    check_field("out_kind_w1", b.kind[95:32], out_kind_w1);
                    check_field("out_kind_w2", b.kind[31:0], out_kind_w2);
                    check_field("out_amount", b.amt, out_amount);
                    check_field("last", b.last, last);
                end
            end
            if (start && !busy)
                predict_table_op(op, {key_w0, key_w1, key_w2, key_w3},
                                 {kind_w0, kind_w1, kind_w2}, amount);
            pending = expected_beats.size();
        end
    end
endmodule

>>> tb/testbench.sv
// testbench top: clock, reset, stimulus and verdict for the item table
`timescale 1ns / 100ps
module testbench;
    import its_pkg::*;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         start = 0;
    logic         busy;
    logic [2:0]   op = '0;
    logic [63:0]  key_w0 = '0;
    logic [63:0]  key_w1 = '0;
    logic [63:0]  key_w2 = '0;
    logic [47:0]  key_w3 = '0;
    logic [63:0]  kind_w0 = '0;
    logic [63:0]  kind_w1 = '0;
    logic [31:0]  kind_w2 = '0;
    logic signed [31:0] amount = '0;
    logic         strobe;
    logic [1:0]   status;
    logic [3:0]   position;
    logic [4:0]   compare_count;
    logic [63:0]  out_key_w0, out_key_w1, out_key_w2;
    logic [47:0]  out_key_w3;
    logic [63:0]  out_kind_w0, out_kind_w1;
    logic [31:0]  out_kind_w2;
    logic signed [31:0] out_amount;
    logic         last;
    int           fail_count;
    int           pending;
    int           beat_count;
    int           item_count = 0;
    logic [239:0] name_pool[8];

    item_table_sort_search u_top (.*);
    item_table_checker u_chk (.*);

    always
    begin
        clk = 1;
        #6;
        clk = 0;
        #6;
    end

    function automatic logic [239:0] rand_name();
        return 240'({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic [239:0] pick_name();
        int r;
        r = $urandom_range(0, 9);
        return (r < 8) ? name_pool[r] : rand_name();
    endfunction

    task automatic send_item(logic [2:0] code, logic [239:0] name,
                             logic [159:0] kind, logic [31:0] amt);
        logic b;
        start   <= 1;
        op      <= code;
        {key_w0, key_w1, key_w2, key_w3} <= name;
        {kind_w0, kind_w1, kind_w2}      <= kind;
        amount  <= amt;
        do
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
        end while (b);
        item_count++;
    endtask

    task automatic send_random(logic [2:0] code);
        send_item(code, pick_name(), {$urandom, $urandom, $urandom, $urandom, $urandom},
                  $urandom);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int r;
        logic [2:0] code;
        name_pool[0] = '0;
        name_pool[1] = '1;
        name_pool[2] = rand_name() & 240'({8{32'hff00_ff00}});
        for (int i = 3; i < 8; i++)
            name_pool[i] = rand_name() & ({240{1'b1}} << (8 * $urandom_range(0, 26)));
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty table
        send_random(OP_LIST);
        send_random(OP_SEQ);
        send_random(OP_BIN);
        send_random(OP_REMOVE);
        send_random(OP_SORT);
        send_item(OP_INSERT, name_pool[1], '1, 32'h7fff_ffff);
        send_item(OP_INSERT, name_pool[0], '0, 32'h8000_0000);
        send_item(OP_INSERT, name_pool[2], {5{32'ha5a5_5a5a}}, 32'hffff_ffff);
        send_item(OP_BIN, name_pool[0], '0, '0);
        send_item(OP_SORT, '0, '0, '0);
        send_item(OP_BIN, name_pool[2], '0, '0);
        send_item(OP_SEQ, name_pool[0], '0, '0);
        send_item(OP_SEQ, rand_name(), '0, '0);
        send_item(OP_BIN, rand_name(), '0, '0);
        send_item(OP_REMOVE, name_pool[0], '0, '0);
        send_item(OP_REMOVE, rand_name(), '0, '0);
        send_random(3'd6);
        send_random(3'd7);
        // fill to capacity, then overflow
        for (int i = 0; i < 15; i++)
            send_random(OP_INSERT);
        send_random(OP_LIST);
        send_random(OP_SORT);
        send_random(OP_BIN);
        drain();

        for (int i = 0; i < 84; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)      code = OP_INSERT;
            else if (r < 52) code = OP_REMOVE;
            else if (r < 60) code = OP_LIST;
            else if (r < 72) code = OP_SEQ;
            else if (r < 80) code = OP_SORT;
            else if (r < 95) code = OP_BIN;
            else             code = 3'($urandom_range(6, 7));
            send_random(code);
            if (i == 60)
                drain();
            else if (i < 64 && $urandom_range(0, 3) == 0)
            begin
                start <= 0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
        drain();
        repeat (40) @(posedge clk);
        if (pending != 0)
            $error("%0d result beats never arrived", pending);
        $display("run covered %0d items on all table operations", item_count);
        $display("%0d result beats checked, %0d mismatches", beat_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/its_pkg.sv
rtl/its_ram.sv
rtl/its_datapath.sv
rtl/its_ctrl.sv
rtl/item_table_sort_search.sv
rtl/its_checker.sv
tb/item_table_checker.sv
tb/testbench.sv
